// ----- hdl/sas_pkg.sv -----
// Shared types, constants and helper functions of the sprite animation sequencer.
// Used by sas_cfg, sas_engine and the top level; depends on nothing else.
package sas_pkg;

  // Default sizes for the top-level and engine parameters
  localparam int unsigned NUM_SEQUENCES_DEF = 16;
  localparam int unsigned SEQ_SLOTS_DEF     = 16;
  localparam int unsigned MAX_FRAMES_DEF    = 64;

  // Command codes carried in the request tuser
  localparam logic [1:0] CMD_TICK     = 2'd0;
  localparam logic [1:0] CMD_WR_ENTRY = 2'd1;
  localparam logic [1:0] CMD_WR_LINK  = 2'd2;

  // Animation modes
  localparam logic [1:0] MODE_SINGLE = 2'd0;
  localparam logic [1:0] MODE_CYCLE  = 2'd1;
  localparam logic [1:0] MODE_SEQ    = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] REG_ANIM_MODE    = 2'd0;
  localparam logic [1:0] REG_ONE_SHOT     = 2'd1;
  localparam logic [1:0] REG_FRAME_PERIOD = 2'd2;
  localparam logic [1:0] REG_FRAME_COUNT  = 2'd3;

  localparam int unsigned CFG_DATA_W = 16;

  typedef struct packed {
    logic [1:0]  anim_mode;
    logic        one_shot;
    logic [15:0] frame_period;
    logic [6:0]  frame_count;
  } sas_cfg_t;

  typedef struct packed {
    logic [1:0] command;
    logic [3:0] anim_select;
    logic [3:0] slot;
    logic [5:0] frame_value;
    logic       end_mark;
    logic [3:0] next_anim;
    logic       next_valid;
  } sas_item_t;

  typedef struct packed {
    logic busy;    // a request is still being worked on
    logic result;  // state now holds the answer to the last request
  } sas_status_t;

  // Table of v mod n for every 4-bit v, 8 bits per entry; elaboration only
  function automatic logic [127:0] wrap_table(int unsigned n);
    logic [127:0] t;
    int unsigned  r;
    t = '0;
    for (int unsigned i = 0; i < 16; i++) begin
      r = i;
      while (r >= n) begin
        r = r - n;
      end
      t[i*8 +: 8] = 8'(r);
    end
    return t;
  endfunction

endpackage

// ----- hdl/sas_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sas_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port and registered read port; read-during-write returns old data
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/sas_cfg.sv -----
// Configuration register file of the sprite animation sequencer.
// Depends on sas_pkg for register indexes and the configuration struct.
module sas_cfg (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  input  logic [1:0]                      cfg_index_i,
  input  logic [sas_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  output sas_pkg::sas_cfg_t               cfg_o
);

  sas_pkg::sas_cfg_t cfg_q, cfg_d;

  // decode the register write
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        sas_pkg::REG_ANIM_MODE:    cfg_d.anim_mode    = cfg_data_i[1:0];
        sas_pkg::REG_ONE_SHOT:     cfg_d.one_shot     = cfg_data_i[0];
        sas_pkg::REG_FRAME_PERIOD: cfg_d.frame_period = cfg_data_i[15:0];
        sas_pkg::REG_FRAME_COUNT:  cfg_d.frame_count  = cfg_data_i[6:0];
        default:                   cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.anim_mode    <= sas_pkg::MODE_SINGLE;
      cfg_q.one_shot     <= 1'b0;
      cfg_q.frame_period <= 16'd0;
      cfg_q.frame_count  <= 7'd1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- hdl/sas_engine.sv -----
// Animation engine: prescaler, frame state and the sequence/link memories.
// Depends on sas_pkg and sas_ram.
module sas_engine #(
  parameter int unsigned NUM_SEQUENCES = sas_pkg::NUM_SEQUENCES_DEF,
  parameter int unsigned SEQ_SLOTS     = sas_pkg::SEQ_SLOTS_DEF,
  parameter int unsigned MAX_FRAMES    = sas_pkg::MAX_FRAMES_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  sas_pkg::sas_cfg_t    cfg_i,
  input  logic                 start_i,
  input  sas_pkg::sas_item_t   item_i,
  output sas_pkg::sas_status_t status_o,
  output logic [5:0]           frame_o,
  output logic [3:0]           animation_o,
  output logic [3:0]           position_o,
  output logic                 done_o
);

  localparam int unsigned SEL_W  = (NUM_SEQUENCES > 1) ? $clog2(NUM_SEQUENCES) : 1;
  localparam int unsigned POS_W  = $clog2(SEQ_SLOTS);
  localparam int unsigned SEQ_D  = NUM_SEQUENCES * SEQ_SLOTS;
  localparam int unsigned SEQ_AW = $clog2(SEQ_D);
  localparam int unsigned FLIM   = (MAX_FRAMES < 64) ? MAX_FRAMES : 64;
  localparam logic [6:0]  FrameLim = 7'(FLIM);
  localparam logic [POS_W-1:0] PosLast = POS_W'(SEQ_SLOTS - 1);
  localparam logic [127:0] SelTab  = sas_pkg::wrap_table(NUM_SEQUENCES);
  localparam logic [127:0] SlotTab = sas_pkg::wrap_table(SEQ_SLOTS);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_ADV   = 3'b010,  // entry at the next position is on the read port
    ST_FETCH = 3'b100   // entry chosen after an end mark is on the read port
  } state_e;

  state_e            state_q, state_d;
  logic [15:0]       tick_q, tick_d;
  logic [5:0]        frame_q, frame_d;
  logic [3:0]        anim_q, anim_d;
  logic [POS_W-1:0]  pos_q, pos_d;
  logic              done_q, done_d;

  logic              seq_we, link_we;
  logic [SEQ_AW-1:0] seq_waddr, seq_raddr;
  logic [6:0]        seq_wdata, seq_rdata;
  logic [SEL_W-1:0]  link_waddr, link_raddr;
  logic [4:0]        link_wdata, link_rdata;

  logic [16:0]       tick_inc;
  logic              fire;
  logic [POS_W-1:0]  pos_inc;
  logic [6:0]        frame_inc;
  logic [SEL_W-1:0]  anim_sel;
  logic [3:0]        new_anim;
  logic              result;

  // sequence number and slot wrap through small constant tables
  function automatic logic [SEL_W-1:0] sel_of(logic [3:0] v);
    return SelTab[{v, 3'b000} +: SEL_W];
  endfunction

  function automatic logic [POS_W-1:0] slot_of(logic [3:0] v);
    return SlotTab[{v, 3'b000} +: POS_W];
  endfunction

  function automatic logic [SEQ_AW-1:0] seq_addr(logic [SEL_W-1:0] s, logic [POS_W-1:0] p);
    return SEQ_AW'(s) * SEQ_AW'(SEQ_SLOTS) + SEQ_AW'(p);
  endfunction

  // memories
  sas_ram #(
    .WIDTH (7),
    .DEPTH (SEQ_D)
  ) u_seq_ram (
    .clk_i   (clk_i),
    .we_i    (seq_we),
    .waddr_i (seq_waddr),
    .wdata_i (seq_wdata),
    .raddr_i (seq_raddr),
    .rdata_o (seq_rdata)
  );

  sas_ram #(
    .WIDTH (5),
    .DEPTH (NUM_SEQUENCES)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (link_we),
    .waddr_i (link_waddr),
    .wdata_i (link_wdata),
    .raddr_i (link_raddr),
    .rdata_o (link_rdata)
  );

  // prescaler and step arithmetic
  assign tick_inc  = {1'b0, tick_q} + 17'd1;
  assign fire      = (tick_inc >= {1'b0, cfg_i.frame_period});
  assign pos_inc   = (pos_q == PosLast) ? '0 : pos_q + POS_W'(1);
  assign frame_inc = {1'b0, frame_q} + 7'd1;
  assign anim_sel  = sel_of(anim_q);
  assign new_anim  = link_rdata[4] ? link_rdata[3:0] : anim_q;

  // write ports follow the request directly
  assign seq_waddr  = seq_addr(sel_of(item_i.anim_select), slot_of(item_i.slot));
  assign seq_wdata  = {item_i.end_mark, item_i.frame_value};
  assign link_waddr = sel_of(item_i.anim_select);
  assign link_wdata = {item_i.next_valid, item_i.next_anim};
  assign link_raddr = anim_sel;

  // sequencer: run requests and table writes, read entry, resolve end mark, write back state
  always_comb begin
    state_d   = state_q;
    tick_d    = tick_q;
    frame_d   = frame_q;
    anim_d    = anim_q;
    pos_d     = pos_q;
    done_d    = done_q;
    seq_we    = 1'b0;
    link_we   = 1'b0;
    seq_raddr = seq_addr(anim_sel, pos_inc);
    result    = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          result = 1'b1;
          case (item_i.command)
            sas_pkg::CMD_TICK: begin
              case (cfg_i.anim_mode)
                sas_pkg::MODE_SINGLE: frame_d = 6'd0;
                sas_pkg::MODE_CYCLE: begin
                  tick_d = fire ? 16'd0 : tick_inc[15:0];
                  if (fire) begin
                    frame_d = (frame_inc >= cfg_i.frame_count || frame_inc >= FrameLim)
                              ? 6'd0 : frame_inc[5:0];
                  end
                end
                sas_pkg::MODE_SEQ: begin
                  tick_d = fire ? 16'd0 : tick_inc[15:0];
                  if (fire) begin
                    result  = 1'b0;
                    state_d = ST_ADV;
                  end
                end
                default: tick_d = tick_q;
              endcase
            end
            sas_pkg::CMD_WR_ENTRY: seq_we  = 1'b1;
            sas_pkg::CMD_WR_LINK:  link_we = 1'b1;
            default:               result  = 1'b1;
          endcase
        end
      end
      ST_ADV: begin
        if (!seq_rdata[6]) begin
          pos_d   = pos_inc;
          frame_d = seq_rdata[5:0];
          result  = 1'b1;
          state_d = ST_IDLE;
        end else if (cfg_i.one_shot) begin
          // hold at the last entry before the end mark
          done_d    = 1'b1;
          seq_raddr = seq_addr(anim_sel, pos_q);
          state_d   = ST_FETCH;
        end else begin
          anim_d    = new_anim;
          pos_d     = '0;
          seq_raddr = seq_addr(sel_of(new_anim), '0);
          state_d   = ST_FETCH;
        end
      end
      ST_FETCH: begin
        frame_d = seq_rdata[5:0];
        result  = 1'b1;
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      tick_q  <= 16'd0;
      frame_q <= 6'd0;
      anim_q  <= 4'd0;
      pos_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      tick_q  <= tick_d;
      frame_q <= frame_d;
      anim_q  <= anim_d;
      pos_q   <= pos_d;
      done_q  <= done_d;
    end
  end

  assign status_o.busy   = (state_q != ST_IDLE);
  assign status_o.result = result;
  assign frame_o         = frame_q;
  assign animation_o     = anim_q;
  assign position_o      = 4'(pos_q);
  assign done_o          = done_q;

`ifndef SYNTH
  // a firing tick in sequence mode always goes to the memory read
  a_seq_fire: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && state_q == ST_IDLE && item_i.command == sas_pkg::CMD_TICK &&
    cfg_i.anim_mode == sas_pkg::MODE_SEQ && fire |=> state_q == ST_ADV)
    else $error("sequence advance did not start a table read");

  // the advance state never repeats back to back
  a_adv_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_ADV |=> state_q != ST_ADV)
    else $error("advance state repeated");

  // done stays set once raised
  a_done_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> done_q)
    else $error("done flag cleared");

  // position never leaves the slot range
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= PosLast)
    else $error("position out of range");
`endif

endmodule

// ----- hdl/sprite_animation_sequencer.sv -----
// Top level of the sprite animation sequencer: stream ports, result register.
// Depends on sas_pkg, sas_cfg, sas_engine (and sas_ram through it).

// Each request (tick, table entry write or link write) produces exactly one
// result holding frame, sequence, position and done flag after the request.
// Writes, ticks outside sequence mode and ticks that do not reach the frame
// period run back to back. A frame advance in sequence mode passes through
// ST_ADV, and also ST_FETCH when the next entry carries an end mark, as the
// single read port of the sequence memory runs its dependent reads (next entry,
// then the entry after the end decision) in turn. Sequence entries and links
// are undefined until written and need no clearing after reset. The result is
// shown straight from the state registers, so a result waiting on the master
// side holds up the next request until it is taken. Configuration must be
// written only while no request is in flight; the block does not enforce it.
module sprite_animation_sequencer #(
  parameter int unsigned NUM_SEQUENCES = sas_pkg::NUM_SEQUENCES_DEF,
  parameter int unsigned SEQ_SLOTS     = sas_pkg::SEQ_SLOTS_DEF,
  parameter int unsigned MAX_FRAMES    = sas_pkg::MAX_FRAMES_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // request stream
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // [3:0] anim_select, [7:4] slot, [13:8] frame_value, [14] end_mark,
  // [18:15] next_anim, [19] next_valid, [23:20] zero
  input  logic [23:0]                    s_axis_tdata,
  // [1:0] command
  input  logic [1:0]                     s_axis_tuser,
  // result stream
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [5:0] frame_out, [9:6] animation_out, [13:10] position_out,
  // [14] done_out, [15] zero
  output logic [15:0]                    m_axis_tdata,
  // configuration writes
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [1:0]                     cfg_index_i,
  input  logic [sas_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  sas_pkg::sas_cfg_t    cfg;
  sas_pkg::sas_item_t   item;
  sas_pkg::sas_status_t status;
  logic                 start;
  logic                 m_valid_q, m_valid_d;
  logic [5:0]           frame;
  logic [3:0]           animation;
  logic [3:0]           position;
  logic                 done;

  assign cfg_ready_o = 1'b1;

  sas_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // unpack the request
  assign item.command     = s_axis_tuser;
  assign item.anim_select = s_axis_tdata[3:0];
  assign item.slot        = s_axis_tdata[7:4];
  assign item.frame_value = s_axis_tdata[13:8];
  assign item.end_mark    = s_axis_tdata[14];
  assign item.next_anim   = s_axis_tdata[18:15];
  assign item.next_valid  = s_axis_tdata[19];

  // take a request when the engine is free and the result slot drains
  assign s_axis_tready = !status.busy && (!m_valid_q || m_axis_tready);
  assign start         = s_axis_tvalid && s_axis_tready;

  sas_engine #(
    .NUM_SEQUENCES (NUM_SEQUENCES),
    .SEQ_SLOTS     (SEQ_SLOTS),
    .MAX_FRAMES    (MAX_FRAMES)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .start_i     (start),
    .item_i      (item),
    .status_o    (status),
    .frame_o     (frame),
    .animation_o (animation),
    .position_o  (position),
    .done_o      (done)
  );

  // result valid; state registers hold still until the next request
  always_comb begin
    m_valid_d = m_valid_q;
    if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
    if (status.result) begin
      m_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else begin
      m_valid_q <= m_valid_d;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {1'b0, done, position, animation, frame};

`ifndef SYNTH
  // a new result never overwrites one that has not been taken
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.result |-> !m_valid_q || m_axis_tready)
    else $error("result produced while previous result pending");
`endif

endmodule
